[rtl/voxel_visible_face_culler_assert.svh]
// Assertion macros used by the culler RTL.
// Each assertion samples on clk and is switched off while rst_n is low.
`ifndef VOXEL_VISIBLE_FACE_CULLER_ASSERT_SVH
`define VOXEL_VISIBLE_FACE_CULLER_ASSERT_SVH

`ifndef SYNTHESIS

`define VVFC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vvfc assertion failed");

`define VVFC_NEVER(lbl, expr) \
    `VVFC_ASSERT(lbl, !(expr))

`else

`define VVFC_ASSERT(lbl, prop)

`define VVFC_NEVER(lbl, expr)

`endif

`endif

[rtl/vvfc_pkg.sv]
`default_nettype none

package vvfc_pkg;

    localparam int GRID_SIDE_DEFAULT = 16;

    localparam int COORD_W = 4;
    localparam int OP_W    = 2;
    localparam int DIR_W   = 3;
    localparam int VB_W    = 17;
    localparam int PHASE_W = 3;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_SCAN    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Probe phases: the scanned cell itself, then its six neighbors in face order.
    localparam logic [PHASE_W-1:0] PH_CELL = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PX   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PY   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_NX   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_NY   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_PZ   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_NZ   = 3'd6;
    localparam logic [PHASE_W-1:0] PH_DONE = 3'd7;

    localparam logic [VB_W-1:0] VB_STEP = 17'd4;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [PHASE_W-1:0] phase_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        phase_t phase;
    } probe_req_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic wdata;
    } mem_req_t;

endpackage

`default_nettype wire

[rtl/vvfc_probe_unit.sv]
`default_nettype none

module vvfc_probe_unit #(
    parameter int GRID_SIDE = vvfc_pkg::GRID_SIDE_DEFAULT,
    localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE * GRID_SIDE)
) (
    input  vvfc_pkg::probe_req_t req,
    output logic [ADDR_W-1:0]    addr,
    output logic                 oob
);

    logic [vvfc_pkg::COORD_W:0] nx;
    logic [vvfc_pkg::COORD_W:0] ny;
    logic [vvfc_pkg::COORD_W:0] nz;
    logic                       low;

    always_comb
    begin
        nx  = {1'b0, req.x};
        ny  = {1'b0, req.y};
        nz  = {1'b0, req.z};
        low = 1'b0;
        unique case (req.phase)
            vvfc_pkg::PH_PX: nx = nx + 1'b1;
            vvfc_pkg::PH_PY: ny = ny + 1'b1;
            vvfc_pkg::PH_NX:
            begin
                low = (req.x == '0);
                nx  = nx - 1'b1;
            end
            vvfc_pkg::PH_NY:
            begin
                low = (req.y == '0);
                ny  = ny - 1'b1;
            end
            vvfc_pkg::PH_PZ: nz = nz + 1'b1;
            vvfc_pkg::PH_NZ:
            begin
                low = (req.z == '0);
                nz  = nz - 1'b1;
            end
            default: ;
        endcase
    end

    // Off the low edge flags directly; the high edge is a compare against the side.
    assign oob = low
              || (32'(nx) >= 32'(GRID_SIDE))
              || (32'(ny) >= 32'(GRID_SIDE))
              || (32'(nz) >= 32'(GRID_SIDE));

    assign addr = ADDR_W'(32'(nz) * 32'(GRID_SIDE * GRID_SIDE)
                        + 32'(ny) * 32'(GRID_SIDE) + 32'(nx));

endmodule

`default_nettype wire

[rtl/vvfc_grid_mem.sv]
`default_nettype none

module vvfc_grid_mem #(
    parameter int GRID_SIDE = vvfc_pkg::GRID_SIDE_DEFAULT,
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE,
    localparam int ADDR_W = $clog2(CELL_COUNT)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vvfc_pkg::mem_req_t req,
    input  logic [ADDR_W-1:0]  addr,
    output logic               rdata,
    output logic               busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

    logic              cells [CELL_COUNT];
    logic              rdata_reg;
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_data;
    logic              rd_en;

    // Sweep every cell to air after reset, one per cycle.
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign wr_en   = clr_busy_reg || req.wr;
    assign wr_addr = clr_busy_reg ? clr_addr_reg : addr;
    assign wr_data = clr_busy_reg ? 1'b0 : req.wdata;
    assign rd_en   = !clr_busy_reg && req.rd;

    // Read data holds when no read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cells[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= cells[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

`default_nettype wire

[rtl/voxel_visible_face_culler.sv]
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------------------
// cmd      | cmd_valid / cmd_stall   | operation, cell_x, cell_y, cell_z, solid
// face     | face_valid / face_stall | face_x, face_y, face_z, direction, vertex_base, last
//
// Write, restart and unused codes complete when accepted; a scan of an air cell ends once
// the cell read shows air. A scan of a solid cell is accepted, then makes seven reads (cell,
// then six neighbors) through the single-port grid memory, one per cycle unless a face is
// held back, then checks the last read and closes. A face stall holds the scan only while a
// found face waits behind a full output. After reset every cell is cleared to air, one per
// cycle (GRID_SIDE^3 cells, 4096 at the default side), with cmd_stall high throughout.
`default_nettype none
`include "voxel_visible_face_culler_assert.svh"

module voxel_visible_face_culler #(
    parameter int GRID_SIDE = vvfc_pkg::GRID_SIDE_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [vvfc_pkg::OP_W-1:0]    operation,
    input  logic [vvfc_pkg::COORD_W-1:0] cell_x,
    input  logic [vvfc_pkg::COORD_W-1:0] cell_y,
    input  logic [vvfc_pkg::COORD_W-1:0] cell_z,
    input  logic                         solid,
    output logic                         face_valid,
    input  logic                         face_stall,
    output logic [vvfc_pkg::COORD_W-1:0] face_x,
    output logic [vvfc_pkg::COORD_W-1:0] face_y,
    output logic [vvfc_pkg::COORD_W-1:0] face_z,
    output logic [vvfc_pkg::DIR_W-1:0]   direction,
    output logic [vvfc_pkg::VB_W-1:0]    vertex_base,
    output logic                         last
);

    localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE * GRID_SIDE);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    vvfc_pkg::coord_t             x_reg;
    vvfc_pkg::coord_t             x_next;
    vvfc_pkg::coord_t             y_reg;
    vvfc_pkg::coord_t             y_next;
    vvfc_pkg::coord_t             z_reg;
    vvfc_pkg::coord_t             z_next;
    vvfc_pkg::phase_t             iss_reg;
    vvfc_pkg::phase_t             iss_next;
    logic                         chk_valid_reg;
    logic                         chk_valid_next;
    vvfc_pkg::phase_t             chk_phase_reg;
    vvfc_pkg::phase_t             chk_phase_next;
    logic                         chk_oob_reg;
    logic                         chk_oob_next;
    logic                         pend_valid_reg;
    logic                         pend_valid_next;
    logic [vvfc_pkg::DIR_W-1:0]   pend_dir_reg;
    logic [vvfc_pkg::DIR_W-1:0]   pend_dir_next;
    logic [vvfc_pkg::VB_W-1:0]    cnt_reg;
    logic [vvfc_pkg::VB_W-1:0]    cnt_next;
    logic                         face_valid_reg;
    logic                         face_valid_next;
    vvfc_pkg::coord_t             face_x_reg;
    vvfc_pkg::coord_t             face_x_next;
    vvfc_pkg::coord_t             face_y_reg;
    vvfc_pkg::coord_t             face_y_next;
    vvfc_pkg::coord_t             face_z_reg;
    vvfc_pkg::coord_t             face_z_next;
    logic [vvfc_pkg::DIR_W-1:0]   face_dir_reg;
    logic [vvfc_pkg::DIR_W-1:0]   face_dir_next;
    logic [vvfc_pkg::VB_W-1:0]    face_vb_reg;
    logic [vvfc_pkg::VB_W-1:0]    face_vb_next;
    logic                         face_last_reg;
    logic                         face_last_next;

    vvfc_pkg::probe_req_t         probe_req;
    logic [ADDR_W-1:0]            probe_addr;
    logic                         probe_oob;
    vvfc_pkg::mem_req_t           mem_req;
    logic                         mem_rdata;
    logic                         mem_busy;

    logic                         cmd_accept;
    logic                         out_free;
    logic                         chk_face;
    logic                         cell_air;
    logic                         scan_end;
    logic                         hold;
    logic                         step;
    logic                         out_load;

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            probe_req = '{x: cell_x, y: cell_y, z: cell_z, phase: vvfc_pkg::PH_CELL};
        end
        else
        begin
            probe_req = '{x: x_reg, y: y_reg, z: z_reg, phase: iss_reg};
        end
    end

    vvfc_probe_unit #(
        .GRID_SIDE (GRID_SIDE)
    ) u_probe (
        .req  (probe_req),
        .addr (probe_addr),
        .oob  (probe_oob)
    );

    vvfc_grid_mem #(
        .GRID_SIDE (GRID_SIDE)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .addr  (probe_addr),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    assign cmd_stall  = mem_busy || (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;

    assign out_free = !face_valid_reg || !face_stall;
    assign chk_face = chk_valid_reg && (chk_phase_reg != vvfc_pkg::PH_CELL)
                   && (chk_oob_reg || !mem_rdata);
    assign cell_air = chk_valid_reg && (chk_phase_reg == vvfc_pkg::PH_CELL) && !mem_rdata;
    assign scan_end = (iss_reg == vvfc_pkg::PH_DONE) && !chk_valid_reg;
    // A newly found face pushes the pending one out; wait if the output is full.
    assign hold     = chk_face && pend_valid_reg && !out_free;
    assign step     = (state_reg == S_SCAN) && !hold && !cell_air && !scan_end;
    assign out_load = (state_reg == S_SCAN) && pend_valid_reg && out_free
                   && (chk_face || scan_end);

    always_comb
    begin
        mem_req.rd    = step && (iss_reg != vvfc_pkg::PH_DONE);
        mem_req.wr    = cmd_accept && (operation == vvfc_pkg::OP_WRITE) && !probe_oob;
        mem_req.wdata = solid;
    end

    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        iss_next        = iss_reg;
        chk_valid_next  = chk_valid_reg;
        chk_phase_next  = chk_phase_reg;
        chk_oob_next    = chk_oob_reg;
        pend_valid_next = pend_valid_reg;
        pend_dir_next   = pend_dir_reg;
        cnt_next        = cnt_reg;
        face_valid_next = face_valid_reg;
        face_x_next     = face_x_reg;
        face_y_next     = face_y_reg;
        face_z_next     = face_z_reg;
        face_dir_next   = face_dir_reg;
        face_vb_next    = face_vb_reg;
        face_last_next  = face_last_reg;

        if (cmd_accept)
        begin
            unique case (operation)
                vvfc_pkg::OP_SCAN:
                begin
                    if (!probe_oob)
                    begin
                        state_next      = S_SCAN;
                        x_next          = cell_x;
                        y_next          = cell_y;
                        z_next          = cell_z;
                        iss_next        = vvfc_pkg::PH_CELL;
                        chk_valid_next  = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                end
                vvfc_pkg::OP_RESTART: cnt_next = '0;
                default: ;
            endcase
        end

        if (state_reg == S_SCAN)
        begin
            if (cell_air)
            begin
                state_next     = S_IDLE;
                chk_valid_next = 1'b0;
            end
            else if (scan_end)
            begin
                if (!pend_valid_reg || out_free)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            else if (step)
            begin
                chk_valid_next = (iss_reg != vvfc_pkg::PH_DONE);
                chk_phase_next = iss_reg;
                chk_oob_next   = probe_oob;
                if (iss_reg != vvfc_pkg::PH_DONE)
                begin
                    iss_next = iss_reg + 1'b1;
                end
                if (chk_face)
                begin
                    pend_valid_next = 1'b1;
                    pend_dir_next   = vvfc_pkg::DIR_W'(chk_phase_reg - vvfc_pkg::PH_PX);
                end
            end
        end

        if (out_load)
        begin
            face_valid_next = 1'b1;
            face_x_next     = x_reg;
            face_y_next     = y_reg;
            face_z_next     = z_reg;
            face_dir_next   = pend_dir_reg;
            face_vb_next    = cnt_reg;
            face_last_next  = scan_end;
            cnt_next        = cnt_reg + vvfc_pkg::VB_STEP;
        end
        else if (!face_stall)
        begin
            face_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            iss_reg        <= vvfc_pkg::PH_CELL;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            face_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            face_valid_reg <= face_valid_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            z_reg          <= z_next;
            chk_phase_reg  <= chk_phase_next;
            chk_oob_reg    <= chk_oob_next;
            pend_dir_reg   <= pend_dir_next;
            face_x_reg     <= face_x_next;
            face_y_reg     <= face_y_next;
            face_z_reg     <= face_z_next;
            face_dir_reg   <= face_dir_next;
            face_vb_reg    <= face_vb_next;
            face_last_reg  <= face_last_next;
        end
    end

    assign face_valid  = face_valid_reg;
    assign face_x      = face_x_reg;
    assign face_y      = face_y_reg;
    assign face_z      = face_z_reg;
    assign direction   = face_dir_reg;
    assign vertex_base = face_vb_reg;
    assign last        = face_last_reg;

    `VVFC_ASSERT(a_vb_step, out_load |=> (cnt_reg == $past(cnt_reg) + vvfc_pkg::VB_STEP))
    `VVFC_ASSERT(a_last_ends_scan, (out_load && scan_end) |=> (state_reg == S_IDLE))
    `VVFC_NEVER(a_idle_no_pend, (state_reg == S_IDLE) && pend_valid_reg)
    `VVFC_NEVER(a_no_load_when_full, out_load && face_valid_reg && face_stall)

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vvfc_pkg::*;

    localparam int SIDE         = GRID_SIDE_DEFAULT;
    localparam int CELLS        = SIDE * SIDE * SIDE;
    localparam int RANDOM_ITEMS = 220;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int MAX_GAP      = 8;
    localparam int MAX_STALL    = 6;
    localparam int SOAK_SCANS   = 24;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [DIR_W-1:0] {
        FACE_PX, FACE_PY, FACE_NX, FACE_NY, FACE_PZ, FACE_NZ
    } face_dir_e;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               solid;
    } cmd_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [DIR_W-1:0]   dir;
        logic [VB_W-1:0]    vbase;
        logic               last;
    } face_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    logic [OP_W-1:0]     operation = '0;
    logic [COORD_W-1:0]  cell_x = '0;
    logic [COORD_W-1:0]  cell_y = '0;
    logic [COORD_W-1:0]  cell_z = '0;
    logic                solid = 1'b0;
    logic                face_valid;
    logic                face_stall = 1'b0;
    logic [COORD_W-1:0]  face_x;
    logic [COORD_W-1:0]  face_y;
    logic [COORD_W-1:0]  face_z;
    logic [DIR_W-1:0]    direction;
    logic [VB_W-1:0]     vertex_base;
    logic                last;

    // predictor state
    logic                solid_map [0:CELLS-1];
    logic [VB_W-1:0]     vertex_count = '0;

    cmd_item_t           cmd_pending [$];
    cmd_item_t           cmd_cur;
    face_item_t          faces_expected [$];

    int                  total_cmds = 0;
    int                  cmds_accepted = 0;
    int                  fault_count = 0;
    longint              cycle_count = 0;
    longint              cycle_limit = 64'd100_000_000;

    int                  burst_left = 0;
    int                  gap_left = 0;
    int                  stall_left = 0;
    int                  free_left = 0;
    int                  hold_left = 0;
    bit                  hold_done = 1'b0;
    int                  rx_taken = 0;

    voxel_visible_face_culler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .operation   (operation),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_z      (cell_z),
        .solid       (solid),
        .face_valid  (face_valid),
        .face_stall  (face_stall),
        .face_x      (face_x),
        .face_y      (face_y),
        .face_z      (face_z),
        .direction   (direction),
        .vertex_base (vertex_base),
        .last        (last)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            solid_map[i] = 1'b0;
        end
    end

    function automatic int cell_index(int x, int y, int z);
        return (z * SIDE + y) * SIDE + x;
    endfunction

    // Apply one accepted item to the grid copy and queue the faces it exposes.
    task automatic predict_faces(input cmd_item_t c);
        face_item_t scan_faces [$];
        face_item_t f;
        face_dir_e  dir;
        int         nx;
        int         ny;
        int         nz;
        bit         open;
        case (c.op)
            OP_WRITE:
            begin
                solid_map[cell_index(c.x, c.y, c.z)] = c.solid;
            end
            OP_RESTART:
            begin
                vertex_count = '0;
            end
            OP_SCAN:
            begin
                if (solid_map[cell_index(c.x, c.y, c.z)])
                begin
                    for (int d = 0; d < 6; d++)
                    begin
                        dir = face_dir_e'(d);
                        nx = c.x;
                        ny = c.y;
                        nz = c.z;
                        case (dir)
                            FACE_PX: nx = nx + 1;
                            FACE_PY: ny = ny + 1;
                            FACE_NX: nx = nx - 1;
                            FACE_NY: ny = ny - 1;
                            FACE_PZ: nz = nz + 1;
                            default: nz = nz - 1;
                        endcase
                        if (nx < 0 || nx >= SIDE || ny < 0 || ny >= SIDE
                            || nz < 0 || nz >= SIDE)
                            open = 1'b1;
                        else
                            open = !solid_map[cell_index(nx, ny, nz)];
                        if (open)
                        begin
                            f.x = c.x;
                            f.y = c.y;
                            f.z = c.z;
                            f.dir = dir;
                            f.vbase = vertex_count;
                            f.last = 1'b0;
                            scan_faces.push_back(f);
                            vertex_count = vertex_count + VB_STEP;
                        end
                    end
                    if (scan_faces.size() > 0)
                        scan_faces[scan_faces.size() - 1].last = 1'b1;
                    foreach (scan_faces[i])
                        faces_expected.push_back(scan_faces[i]);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_cmd(input logic [OP_W-1:0] op, input int x, input int y,
                             input int z, input logic s);
        cmd_item_t c;
        c.op = op;
        c.x = x[COORD_W-1:0];
        c.y = y[COORD_W-1:0];
        c.z = z[COORD_W-1:0];
        c.solid = s;
        cmd_pending.push_back(c);
    endtask

    // Region corners lean toward the grid edges so boundary faces show up often.
    function automatic int region_origin();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return SIDE - 4;
            default: return $urandom_range(0, SIDE - 4);
        endcase
    endfunction

    task automatic report_fault(input string what, input face_item_t e,
                                input face_item_t g, input bit has_exp);
        fault_count++;
        if (fault_count <= 10)
        begin
            if (has_exp)
            begin
                $write("%s: expected x=%0d y=%0d z=%0d dir=%0d vb=%0d last=%0d, ",
                       what, e.x, e.y, e.z, e.dir, e.vbase, e.last);
                $display("got x=%0d y=%0d z=%0d dir=%0d vb=%0d last=%0d",
                         g.x, g.y, g.z, g.dir, g.vbase, g.last);
            end
            else
                $display("%s: got x=%0d y=%0d z=%0d dir=%0d vb=%0d last=%0d",
                         what, g.x, g.y, g.z, g.dir, g.vbase, g.last);
        end
    endtask

    // Driver: bursts of items from the pending queue with random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                predict_faces(cmd_cur);
                cmds_accepted++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (cmd_pending.size() > 0)
                begin
                    cmd_cur = cmd_pending.pop_front();
                    operation <= cmd_cur.op;
                    cell_x <= cmd_cur.x;
                    cell_y <= cmd_cur.y;
                    cell_z <= cmd_cur.z;
                    solid <= cmd_cur.solid;
                    cmd_valid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
                    end
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off once traffic is flowing.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            face_stall <= 1'b0;
        end
        else
        begin
            if (face_valid && !face_stall)
                rx_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                face_stall <= 1'b1;
            end
            else if (!hold_done && rx_taken >= 40)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                face_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                face_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                face_stall <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: free_left = 60;
                    1, 2: free_left = $urandom_range(1, 10);
                    default: stall_left = $urandom_range(1, MAX_STALL);
                endcase
                face_stall <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted face with the oldest expectation.
    always @(posedge clk)
    begin
        face_item_t got;
        face_item_t exp_face;
        if (rst_n && face_valid && !face_stall)
        begin
            got.x = face_x;
            got.y = face_y;
            got.z = face_z;
            got.dir = direction;
            got.vbase = vertex_base;
            got.last = last;
            if (faces_expected.size() == 0)
            begin
                report_fault("unexpected face", got, got, 1'b0);
            end
            else
            begin
                exp_face = faces_expected.pop_front();
                if (got.x !== exp_face.x || got.y !== exp_face.y || got.z !== exp_face.z
                    || got.dir !== exp_face.dir || got.vbase !== exp_face.vbase
                    || got.last !== exp_face.last)
                    report_fault("face mismatch", exp_face, got, 1'b1);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int rand_items;
        int bx;
        int by;
        int bz;
        int n;

        // corners, one open and one air scan
        queue_cmd(OP_WRITE, 0, 0, 0, 1'b1);
        queue_cmd(OP_SCAN, 0, 0, 0, 1'b0);
        queue_cmd(OP_SCAN, 15, 15, 15, 1'b1);
        queue_cmd(OP_WRITE, 15, 15, 15, 1'b1);
        queue_cmd(OP_SCAN, 15, 15, 15, 1'b0);
        queue_cmd(OP_UNUSED, 15, 15, 15, 1'b1);
        // fully enclosed cell, then a neighbor with one hidden face
        queue_cmd(OP_WRITE, 5, 5, 5, 1'b1);
        queue_cmd(OP_WRITE, 6, 5, 5, 1'b1);
        queue_cmd(OP_WRITE, 4, 5, 5, 1'b1);
        queue_cmd(OP_WRITE, 5, 6, 5, 1'b1);
        queue_cmd(OP_WRITE, 5, 4, 5, 1'b1);
        queue_cmd(OP_WRITE, 5, 5, 6, 1'b1);
        queue_cmd(OP_WRITE, 5, 5, 4, 1'b1);
        queue_cmd(OP_SCAN, 5, 5, 5, 1'b1);
        queue_cmd(OP_SCAN, 6, 5, 5, 1'b0);
        queue_cmd(OP_RESTART, 9, 3, 12, 1'b1);
        queue_cmd(OP_SCAN, 5, 4, 5, 1'b0);
        queue_cmd(OP_WRITE, 0, 0, 0, 1'b0);
        queue_cmd(OP_SCAN, 0, 0, 0, 1'b1);
        queue_cmd(OP_UNUSED, 10, 6, 3, 1'b0);

        // back-to-back six-face scans of an isolated cell
        queue_cmd(OP_WRITE, 10, 2, 9, 1'b1);
        queue_cmd(OP_RESTART, 0, 0, 0, 1'b0);
        for (int i = 0; i < SOAK_SCANS; i++)
            queue_cmd(OP_SCAN, 10, 2, 9, 1'b0);
        queue_cmd(OP_WRITE, 10, 2, 9, 1'b0);

        // random clusters: fill a small region, then scan inside it
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            bx = region_origin();
            by = region_origin();
            bz = region_origin();
            n = $urandom_range(4, 12);
            for (int i = 0; i < n; i++)
                queue_cmd(OP_WRITE, bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                          bz + $urandom_range(0, 3), $urandom_range(0, 3) != 0);
            rand_items += n;
            n = $urandom_range(3, 8);
            for (int i = 0; i < n; i++)
                queue_cmd(OP_SCAN, bx + $urandom_range(0, 3), by + $urandom_range(0, 3),
                          bz + $urandom_range(0, 3), $urandom_range(0, 1));
            rand_items += n;
            if ($urandom_range(0, 5) == 0)
            begin
                queue_cmd(OP_RESTART, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 1));
                rand_items++;
            end
            if ($urandom_range(0, 4) == 0)
                queue_cmd(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
            begin
                queue_cmd($urandom_range(0, 1) ? OP_SCAN : OP_WRITE, $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
                rand_items++;
            end
        end

        total_cmds = cmd_pending.size();
        cycle_limit = 4 * (longint'(CELLS) + longint'(total_cmds)
                      * (12 + 6 * (MAX_STALL + 2) + MAX_GAP) + HOLD_CYCLES);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (cmds_accepted < total_cmds)
            @(posedge clk);
        while (faces_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
